// ===== rtl/mck_pkg.sv =====
// shared types, constants and the morse code table for the keyer
`default_nettype none

package mck_pkg;

  localparam int ELEM_W  = 6;   // longest code in the table
  localparam int LEN_W   = 3;   // holds an element count up to ELEM_W
  localparam int GAP_W   = 3;   // holds a gap count, up to SPACE_PERIODS
  localparam int UNIT_W  = 16;
  localparam int DUR_W   = 18;
  localparam int CHAR_W  = 8;

  localparam logic [UNIT_W-1:0] UNIT_RESET    = 16'd71;
  localparam logic [CHAR_W-1:0] SPACE_CHAR    = 8'h20;
  localparam logic [GAP_W-1:0]  GAP_PERIODS   = 3'd2;
  // space: five off periods plus the trailing character gap
  localparam logic [GAP_W-1:0]  SPACE_PERIODS = 3'd7;

  // elements left aligned, first element in the top bit, 1 = dash
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [ELEM_W-1:0] pat;
  } code_t;

  // one keying period handed from the sequencer to the output stage
  typedef struct packed {
    logic led_on;
    logic dash;
    logic last;
  } period_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_ON,
    SEQ_OFF,
    SEQ_GAP
  } seq_state_t;

  function automatic code_t code_lookup(input logic [CHAR_W-1:0] ch);
    code_t c;
    c = '{len: 3'd0, pat: 6'b000000};
    case (ch)
      "A": c = '{len: 3'd2, pat: 6'b010000};
      "B": c = '{len: 3'd4, pat: 6'b100000};
      "C": c = '{len: 3'd4, pat: 6'b101000};
      "D": c = '{len: 3'd3, pat: 6'b100000};
      "E": c = '{len: 3'd1, pat: 6'b000000};
      "F": c = '{len: 3'd4, pat: 6'b001000};
      "G": c = '{len: 3'd3, pat: 6'b110000};
      "H": c = '{len: 3'd4, pat: 6'b000000};
      "I": c = '{len: 3'd2, pat: 6'b000000};
      "J": c = '{len: 3'd4, pat: 6'b011100};
      "K": c = '{len: 3'd3, pat: 6'b101000};
      "L": c = '{len: 3'd4, pat: 6'b010000};
      "M": c = '{len: 3'd2, pat: 6'b110000};
      "N": c = '{len: 3'd2, pat: 6'b100000};
      "O": c = '{len: 3'd3, pat: 6'b111000};
      "P": c = '{len: 3'd4, pat: 6'b011000};
      "Q": c = '{len: 3'd4, pat: 6'b110100};
      "R": c = '{len: 3'd3, pat: 6'b010000};
      "S": c = '{len: 3'd3, pat: 6'b000000};
      "T": c = '{len: 3'd1, pat: 6'b100000};
      "U": c = '{len: 3'd3, pat: 6'b001000};
      "V": c = '{len: 3'd4, pat: 6'b000100};
      "W": c = '{len: 3'd3, pat: 6'b011000};
      "X": c = '{len: 3'd4, pat: 6'b100100};
      "Y": c = '{len: 3'd4, pat: 6'b101100};
      "Z": c = '{len: 3'd4, pat: 6'b110000};
      "1": c = '{len: 3'd5, pat: 6'b011110};
      "2": c = '{len: 3'd5, pat: 6'b001110};
      "3": c = '{len: 3'd5, pat: 6'b000110};
      "4": c = '{len: 3'd5, pat: 6'b000010};
      "5": c = '{len: 3'd5, pat: 6'b000000};
      "6": c = '{len: 3'd5, pat: 6'b100000};
      "7": c = '{len: 3'd5, pat: 6'b110000};
      "8": c = '{len: 3'd5, pat: 6'b111000};
      "9": c = '{len: 3'd5, pat: 6'b111100};
      "0": c = '{len: 3'd5, pat: 6'b111110};
      ".": c = '{len: 3'd6, pat: 6'b010101};
      ",": c = '{len: 3'd6, pat: 6'b110011};
      "?": c = '{len: 3'd6, pat: 6'b001100};
      "!": c = '{len: 3'd6, pat: 6'b101011};
      ":": c = '{len: 3'd6, pat: 6'b111000};
      ";": c = '{len: 3'd6, pat: 6'b101010};
      "(": c = '{len: 3'd5, pat: 6'b101100};
      ")": c = '{len: 3'd6, pat: 6'b101101};
      8'h22: c = '{len: 3'd6, pat: 6'b010010};
      "@": c = '{len: 3'd6, pat: 6'b011010};
      "&": c = '{len: 3'd5, pat: 6'b010000};
      default: c = '{len: 3'd0, pat: 6'b000000};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mck_seq.sv =====
// element sequencer: walks a code one element per step and emits periods
`default_nettype none

module mck_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire mck_pkg::code_t  code,
  input  wire logic            is_space,
  input  wire logic            adv,
  output logic                 busy,
  output logic                 prd_valid,
  output mck_pkg::period_t     prd
);
  import mck_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [ELEM_W-1:0] pat_r, pat_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [GAP_W-1:0]  gap_r, gap_nxt;
  logic              step;

  assign step = prd_valid & adv;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: begin
        if (load) begin
          if (!is_space && (code.len != '0)) state_nxt = SEQ_ON;
          else state_nxt = SEQ_GAP;
        end
      end
      SEQ_ON: begin
        if (step) state_nxt = SEQ_OFF;
      end
      SEQ_OFF: begin
        if (step) state_nxt = (cnt_r == LEN_W'(1)) ? SEQ_GAP : SEQ_ON;
      end
      SEQ_GAP: begin
        if (step && (gap_r == GAP_W'(1))) state_nxt = SEQ_IDLE;
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // shift register and counters
  always_comb begin
    pat_nxt = pat_r;
    cnt_nxt = cnt_r;
    gap_nxt = gap_r;
    if (load && (state_r == SEQ_IDLE)) begin
      pat_nxt = code.pat;
      cnt_nxt = code.len;
      gap_nxt = is_space ? SPACE_PERIODS : GAP_PERIODS;
    end else if (step && (state_r == SEQ_OFF)) begin
      pat_nxt = {pat_r[ELEM_W-2:0], 1'b0};
      cnt_nxt = cnt_r - LEN_W'(1);
    end else if (step && (state_r == SEQ_GAP)) begin
      gap_nxt = gap_r - GAP_W'(1);
    end
  end

  // outputs
  always_comb begin
    busy       = 1'b1;
    prd_valid  = 1'b1;
    prd.led_on = 1'b0;
    prd.dash   = 1'b0;
    prd.last   = 1'b0;
    case (state_r)
      SEQ_IDLE: begin
        busy      = 1'b0;
        prd_valid = 1'b0;
      end
      SEQ_ON: begin
        prd.led_on = 1'b1;
        prd.dash   = pat_r[ELEM_W-1];
      end
      SEQ_OFF: begin
        prd.led_on = 1'b0;
      end
      SEQ_GAP: begin
        prd.last = (gap_r == GAP_W'(1));
      end
      default: begin
        prd_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
    cnt_r <= cnt_nxt;
    gap_r <= gap_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/morse_code_keyer.sv =====
// morse code keyer top level: table lookup, element sequencer, output register
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in_     | request in| in_valid / in_stall| in_character[7:0]
//  out_    | period out| out_valid/out_stall| out_led_on, out_duration_us, out_last
//  cfg_    | write in  | cfg_valid/cfg_ready| cfg_data[15:0] (unit length in us)
//
// a request is loaded, then one period is emitted per cycle while the output
// does not stall; the sequencer steps one code element at a time
// rst_n is synchronous; it empties the output register and sets the unit
// length back to 71 us
// in_stall is high from the cycle after a request is taken until its last
// period has entered the output register; out_stall freezes the sequencer
// while the output register holds an untaken period
`default_nettype none

module morse_code_keyer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // character requests
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mck_pkg::CHAR_W-1:0]    in_character,
  // keying periods
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_led_on,
  output logic [mck_pkg::DUR_W-1:0]          out_duration_us,
  output logic                               out_last,
  // unit length register
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mck_pkg::UNIT_W-1:0]    cfg_data
);
  import mck_pkg::*;

  logic [UNIT_W-1:0] unit_r, unit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_led_on_r;
  logic [DUR_W-1:0]  out_dur_r;
  logic              out_last_r;

  logic              in_take;
  logic              seq_busy;
  logic              prd_valid;
  period_t           prd;
  logic              adv;
  logic              prd_take;
  code_t             code;
  logic              is_space;
  logic [DUR_W-1:0]  dur_one;
  logic [DUR_W-1:0]  dur_three;

  // register writes are only expected while idle, so always ready
  assign cfg_ready = 1'b1;
  assign unit_nxt  = (cfg_valid && cfg_ready) ? cfg_data : unit_r;

  // one request at a time: the sequencer must be back in idle
  assign in_stall = seq_busy;
  assign in_take  = in_valid & ~in_stall;

  assign code     = code_lookup(in_character);
  assign is_space = (in_character == SPACE_CHAR);

  // output register can take a period when empty or being drained
  assign adv      = ~out_valid_r | ~out_stall;
  assign prd_take = prd_valid & adv;

  // dash is three units: u + 2u
  assign dur_one   = {{(DUR_W-UNIT_W){1'b0}}, unit_r};
  assign dur_three = dur_one + {dur_one[DUR_W-2:0], 1'b0};

  mck_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_take),
    .code      (code),
    .is_space  (is_space),
    .adv       (adv),
    .busy      (seq_busy),
    .prd_valid (prd_valid),
    .prd       (prd)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (prd_take) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r      <= UNIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      unit_r      <= unit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, loaded only when a new period enters
  always_ff @(posedge clk) begin
    if (prd_take) begin
      out_led_on_r <= prd.led_on;
      out_dur_r    <= prd.dash ? dur_three : dur_one;
      out_last_r   <= prd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_on      = out_led_on_r;
  assign out_duration_us = out_dur_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/mck_checker.sv =====
// port level checks for the morse keyer, bound to the top level
`default_nettype none

module mck_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic                       out_led_on,
  input wire logic [mck_pkg::DUR_W-1:0]  out_duration_us,
  input wire logic                       out_last
);
  import mck_pkg::*;

  // held period stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // held period payload does not move
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_led_on) && $stable(out_duration_us)
                               && $stable(out_last))
    else $error("out payload changed while stalled");

  // a taken request keeps the keyer busy for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken back to back");

  // the closing period of a character is always an off gap
  a_last_is_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_led_on)
    else $error("last period has the led on");

endmodule

bind morse_code_keyer mck_checker u_mck_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_led_on      (out_led_on),
  .out_duration_us (out_duration_us),
  .out_last        (out_last)
);

`default_nettype wire
